FILE: rtl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and codes for the periodic task scheduler: request and
// response items, slot layout, datapath command and status groups.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

    // Default table depth
    localparam int DEF_MAX_SLOTS = 16;

    // Most fired results reported for one tick
    localparam int RESULTS_CAP = 16;
    localparam int REP_W       = $clog2(RESULTS_CAP + 1);

    // Request kinds
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] now_ms;
        logic [7:0]  handler;
        logic [31:0] period_ms;
    } req_item_t;

    typedef struct packed {
        logic       fired;
        logic [7:0] fired_handler;
        logic [1:0] status;
        logic       last;
    } rsp_item_t;

    // One table entry as held in the slot RAM
    typedef struct packed {
        logic [7:0]  handler;
        logic [31:0] period;
        logic [31:0] last_fire;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    // Source of the slot RAM write data
    typedef enum logic [1:0] {
        WSEL_ADD   = 2'd0,   // new slot from the request
        WSEL_FIRE  = 2'd1,   // read slot with last-fire set to now
        WSEL_SHIFT = 2'd2    // read slot moved down one place
    } wsel_t;

    // Controller to datapath
    typedef struct packed {
        logic       load;        // latch the request item
        logic       we;          // write the slot RAM
        wsel_t      wsel;
        logic       pend_set;    // hold the read handler as pending result
        logic       push_pend;   // send pending result, not last
        logic       push_final;  // send the closing result
        logic [1:0] fin_status;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic due;       // read slot has reached its interval
        logic match;     // read slot handler equals request handler
        logic out_free;  // output register can take an item
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/pts_ram.sv
// ----------------------------------------------------------------------------
// pts_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read, read data registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/pts_ctrl.sv
// ----------------------------------------------------------------------------
// pts_ctrl
// Sequencer for the scheduler: walks the slot table for ticks and removes,
// appends slots for adds, keeps the slot count and orders the results.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_ctrl #(
    parameter int MAX_SLOTS = pts_pkg::DEF_MAX_SLOTS,
    localparam int AW       = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
    localparam int CW       = $clog2(MAX_SLOTS + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic [1:0]         req_kind,
    output logic               req_ready,
    input  pts_pkg::dp_stat_t  stat,
    output pts_pkg::dp_cmd_t   cmd,
    output logic [AW-1:0]      raddr,
    output logic [AW-1:0]      waddr
);

    import pts_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_READ     = 7'b0000010,
        S_EVAL     = 7'b0000100,
        S_SHIFT_RD = 7'b0001000,
        S_SHIFT_WR = 7'b0010000,
        S_ADD      = 7'b0100000,
        S_FINISH   = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [REP_W-1:0] rep_reg, rep_next;
    logic [1:0]       fin_reg, fin_next;
    logic [1:0]       kind_reg, kind_next;
    logic [CW:0]      idx_inc;
    logic [CW-1:0]    idx_dec;
    logic             more;
    logic             report;
    logic             stall;

    // Walk helpers
    assign idx_inc = {1'b0, idx_reg} + (CW+1)'(1);
    assign idx_dec = idx_reg - CW'(1);
    assign more    = idx_inc < {1'b0, count_reg};
    assign report  = stat.due && (rep_reg < REP_W'(RESULTS_CAP));
    assign stall   = report && (rep_reg != '0) && !stat.out_free;

    assign req_ready = (state_reg == S_IDLE);
    assign raddr     = idx_reg[AW-1:0];

    // Pick the write address
    always_comb
    begin
        case (state_reg)
            S_ADD:      waddr = count_reg[AW-1:0];
            S_SHIFT_WR: waddr = idx_dec[AW-1:0];
            default:    waddr = idx_reg[AW-1:0];
        endcase
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        rep_next       = rep_reg;
        fin_next       = fin_reg;
        kind_next      = kind_reg;
        cmd            = '0;
        cmd.wsel       = WSEL_ADD;
        cmd.fin_status = fin_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load  = 1'b1;
                    kind_next = req_kind;
                    idx_next  = '0;
                    rep_next  = '0;
                    fin_next  = ST_OK;
                    case (req_kind)
                        KIND_TICK:
                        begin
                            state_next = (count_reg == '0) ? S_FINISH : S_READ;
                        end
                        KIND_ADD:
                        begin
                            if (count_reg >= CW'(MAX_SLOTS))
                            begin
                                fin_next   = ST_FULL;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_ADD;
                            end
                        end
                        KIND_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                fin_next   = ST_NOT_FOUND;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (kind_reg == KIND_TICK)
                begin
                    // Hold while a pending result cannot leave
                    if (!stall)
                    begin
                        if (stat.due)
                        begin
                            cmd.we   = 1'b1;
                            cmd.wsel = WSEL_FIRE;
                        end
                        if (report)
                        begin
                            cmd.pend_set  = 1'b1;
                            cmd.push_pend = (rep_reg != '0);
                            rep_next      = rep_reg + REP_W'(1);
                        end
                        if (more)
                        begin
                            idx_next   = idx_inc[CW-1:0];
                            state_next = S_READ;
                        end
                        else
                        begin
                            state_next = S_FINISH;
                        end
                    end
                end
                else
                begin
                    // Remove: search for the first matching handler
                    if (stat.match)
                    begin
                        if (more)
                        begin
                            idx_next   = idx_inc[CW-1:0];
                            state_next = S_SHIFT_RD;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                            state_next = S_FINISH;
                        end
                    end
                    else if (more)
                    begin
                        idx_next   = idx_inc[CW-1:0];
                        state_next = S_READ;
                    end
                    else
                    begin
                        fin_next   = ST_NOT_FOUND;
                        state_next = S_FINISH;
                    end
                end
            end
            S_SHIFT_RD:
            begin
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                // Move the read slot down one place
                cmd.we   = 1'b1;
                cmd.wsel = WSEL_SHIFT;
                if (more)
                begin
                    idx_next   = idx_inc[CW-1:0];
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_FINISH;
                end
            end
            S_ADD:
            begin
                cmd.we     = 1'b1;
                cmd.wsel   = WSEL_ADD;
                count_next = count_reg + CW'(1);
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.push_final = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rep_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rep_reg   <= rep_next;
        end
    end

    // Walk position and item attributes
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        fin_reg  <= fin_next;
        kind_reg <= kind_next;
    end

endmodule

`default_nettype wire

FILE: rtl/pts_dp.sv
// ----------------------------------------------------------------------------
// pts_dp
// Datapath of the scheduler: request latch, slot RAM, due and match
// compare, pending fired result and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_dp #(
    parameter int MAX_SLOTS = pts_pkg::DEF_MAX_SLOTS,
    localparam int AW       = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pts_pkg::req_item_t req,
    input  pts_pkg::dp_cmd_t   cmd,
    input  logic [AW-1:0]      raddr,
    input  logic [AW-1:0]      waddr,
    output pts_pkg::dp_stat_t  stat,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output pts_pkg::rsp_item_t rsp
);

    import pts_pkg::*;

    req_item_t         item_reg;
    slot_t             rd_slot;
    slot_t             wr_slot;
    logic [SLOT_W-1:0] rdata;
    logic [31:0]       elapsed;
    logic              pend_valid_reg, pend_valid_next;
    logic [7:0]        pend_handler_reg;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_item_t         rsp_reg, rsp_next;

    // Latch the request item
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= req;
        end
    end

    // Build the slot write data
    always_comb
    begin
        case (cmd.wsel)
            WSEL_ADD:   wr_slot = '{handler: item_reg.handler,
                                    period: item_reg.period_ms,
                                    last_fire: 32'd0};
            WSEL_FIRE:  wr_slot = '{handler: rd_slot.handler,
                                    period: rd_slot.period,
                                    last_fire: item_reg.now_ms};
            WSEL_SHIFT: wr_slot = rd_slot;
            default:    wr_slot = rd_slot;
        endcase
    end

    pts_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (cmd.we),
        .waddr (waddr),
        .wdata (wr_slot),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_slot = slot_t'(rdata);

    // Due on wrapping elapsed time, match on handler
    assign elapsed        = item_reg.now_ms - rd_slot.last_fire;
    assign stat.due       = (elapsed >= rd_slot.period);
    assign stat.match     = (rd_slot.handler == item_reg.handler);
    assign stat.out_free  = !rsp_valid_reg || rsp_ready;

    // Pending fired result
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (cmd.load || cmd.push_final)
        begin
            pend_valid_next = 1'b0;
        end
        else if (cmd.pend_set)
        begin
            pend_valid_next = 1'b1;
        end
    end

    // Output register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (cmd.push_pend)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = '{fired: 1'b1, fired_handler: pend_handler_reg,
                               status: ST_OK, last: 1'b0};
        end
        else if (cmd.push_final)
        begin
            rsp_valid_next = 1'b1;
            if (pend_valid_reg)
            begin
                rsp_next = '{fired: 1'b1, fired_handler: pend_handler_reg,
                             status: ST_OK, last: 1'b1};
            end
            else
            begin
                rsp_next = '{fired: 1'b0, fired_handler: 8'd0,
                             status: cmd.fin_status, last: 1'b1};
            end
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (cmd.pend_set)
        begin
            pend_handler_reg <= rd_slot.handler;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

FILE: rtl/periodic_task_scheduler_top.sv
// ----------------------------------------------------------------------------
// periodic_task_scheduler_top
// Ordered table of periodic slots: add, remove and tick items; a tick
// reports each due slot in table order, at most RESULTS_CAP per tick.
//
//   Channel | Signals                        | Direction | Item
//   --------+--------------------------------+-----------+---------------------
//   req     | req_valid, req_ready, req      | in        | tick / add / remove
//   rsp     | rsp_valid, rsp_ready, rsp      | out       | fired slot or status
//
// One item at a time. A tick reads each slot in S_READ and evaluates and
// writes it back in S_EVAL, as the slot RAM read is registered; a remove
// searches the same way and then moves each later slot down through
// S_SHIFT_RD and S_SHIFT_WR; an add writes its slot in S_ADD.
// A stalled rsp channel holds the walk at the next due slot.
// Reset clears the slot count; the slot RAM needs no clearing.
// The next item is taken while the closing result still waits in rsp.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_task_scheduler_top #(
    parameter int MAX_SLOTS = pts_pkg::DEF_MAX_SLOTS,
    localparam int AW       = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  pts_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output pts_pkg::rsp_item_t rsp
);

    import pts_pkg::*;

    dp_cmd_t       cmd;
    dp_stat_t      stat;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;

    pts_ctrl #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_kind  (req.kind),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd),
        .raddr     (raddr),
        .waddr     (waddr)
    );

    pts_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .raddr     (raddr),
        .waddr     (waddr),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // A result is only pushed when the output register can take it
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push_pend || cmd.push_final) |-> stat.out_free)
        else $error("result pushed into a full output register");

    // Only one result source per cycle
    a_push_one: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.push_pend && cmd.push_final))
        else $error("pending and closing result pushed together");

    // An accepted item keeps the block busy for at least the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken again right after an accept");

    // A result that names no slot carries handler zero
    a_empty_handler: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.fired) |-> (rsp.fired_handler == 8'd0))
        else $error("non-fired result with a handler id");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for periodic_task_scheduler_top. It drives tick, add
// and remove items and keeps its own copy of the slot table to predict every
// response. Responses are checked in order, field by field, while both
// channels stall at random and the response side is held off for a long time.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pts_pkg::*;

    localparam int         TBL_DEPTH       = DEF_MAX_SLOTS;
    localparam logic [1:0] KIND_UNUSED     = 2'd3;
    // Slowest remove walks and shifts a full table
    localparam int         SETTLE_CYCLES   = 100;
    localparam int         HOLD_OFF_CYCLES = 300;
    // ~310 items, up to 16 responses each behind a 61% stall, plus hold-off
    localparam int         CYCLE_LIMIT     = 400000;
    localparam int         PRINT_LIMIT     = 40;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_item_t req       = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_item_t rsp;

    periodic_task_scheduler_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // Shadow slot table
    logic [7:0]  tbl_handler  [TBL_DEPTH];
    logic [31:0] tbl_period   [TBL_DEPTH];
    logic [31:0] tbl_fired_at [TBL_DEPTH];
    int          tbl_count = 0;

    rsp_item_t   expected_rsp_q [$];
    logic [31:0] clock_ms = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_len      = 0;
    int hold_seq      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    int mismatches  = 0;
    int cycle_count = 0;
    int req_sent    = 0;
    int rsp_seen    = 0;
    int fired_seen  = 0;
    int full_seen   = 0;
    int absent_seen = 0;

    // Clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic rsp_item_t make_rsp(logic fired, logic [7:0] hnd,
                                           logic [1:0] status, logic last);
        rsp_item_t r;
        r.fired         = fired;
        r.fired_handler = hnd;
        r.status        = status;
        r.last          = last;
        return r;
    endfunction

    function automatic req_item_t make_req(logic [1:0] kind, logic [31:0] now_ms,
                                           logic [7:0] handler, logic [31:0] period_ms);
        req_item_t it;
        it.kind      = kind;
        it.now_ms    = now_ms;
        it.handler   = handler;
        it.period_ms = period_ms;
        return it;
    endfunction

    // Apply one accepted item to the shadow table and queue its responses
    function automatic void advance_timer_table(req_item_t item);
        logic [31:0] elapsed;
        bit          due [TBL_DEPTH];
        int          n_due;
        int          n_rep;
        int          k;
        int          pos;
        n_due = 0;
        k     = 0;
        pos   = -1;
        case (item.kind)
            KIND_TICK:
            begin
                for (int i = 0; i < tbl_count; i++)
                begin
                    elapsed = item.now_ms - tbl_fired_at[i];
                    due[i]  = (elapsed >= tbl_period[i]);
                    if (due[i])
                    begin
                        n_due++;
                        tbl_fired_at[i] = item.now_ms;
                    end
                end
                n_rep = (n_due > RESULTS_CAP) ? RESULTS_CAP : n_due;
                for (int i = 0; i < tbl_count; i++)
                begin
                    if (due[i] && k < n_rep)
                    begin
                        expected_rsp_q.push_back(make_rsp(1'b1, tbl_handler[i], ST_OK,
                                                          k == n_rep - 1));
                        k++;
                    end
                end
                if (n_due == 0)
                    expected_rsp_q.push_back(make_rsp(1'b0, 8'h00, ST_OK, 1'b1));
            end
            KIND_ADD:
            begin
                if (tbl_count >= TBL_DEPTH)
                    expected_rsp_q.push_back(make_rsp(1'b0, 8'h00, ST_FULL, 1'b1));
                else
                begin
                    tbl_handler[tbl_count]  = item.handler;
                    tbl_period[tbl_count]   = item.period_ms;
                    tbl_fired_at[tbl_count] = '0;
                    tbl_count++;
                    expected_rsp_q.push_back(make_rsp(1'b0, 8'h00, ST_OK, 1'b1));
                end
            end
            KIND_REMOVE:
            begin
                for (int i = 0; i < tbl_count; i++)
                    if (pos < 0 && tbl_handler[i] == item.handler)
                        pos = i;
                if (pos < 0)
                    expected_rsp_q.push_back(make_rsp(1'b0, 8'h00, ST_NOT_FOUND, 1'b1));
                else
                begin
                    // close the gap, keep the order
                    for (int j = pos; j < tbl_count - 1; j++)
                    begin
                        tbl_handler[j]  = tbl_handler[j + 1];
                        tbl_period[j]   = tbl_period[j + 1];
                        tbl_fired_at[j] = tbl_fired_at[j + 1];
                    end
                    tbl_count--;
                    expected_rsp_q.push_back(make_rsp(1'b0, 8'h00, ST_OK, 1'b1));
                end
            end
            default:
                expected_rsp_q.push_back(make_rsp(1'b0, 8'h00, ST_OK, 1'b1));
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("response %0d: %s is %0h, expected %0h",
                                      rsp_seen, name, got, want));
    endtask

    // Check each accepted response against the oldest expectation
    always @(posedge clk)
    begin : check_rsp
        rsp_item_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            rsp_seen++;
            if (expected_rsp_q.size() == 0)
                report_mismatch($sformatf(
                    "unexpected response fired=%0b handler=%0h status=%0d last=%0b",
                    rsp.fired, rsp.fired_handler, rsp.status, rsp.last));
            else
            begin
                want = expected_rsp_q.pop_front();
                fired_seen  += (want.fired == 1'b1);
                full_seen   += (want.status == ST_FULL);
                absent_seen += (want.status == ST_NOT_FOUND);
                check_field("fired", 8'(rsp.fired), 8'(want.fired));
                check_field("fired_handler", rsp.fired_handler, want.fired_handler);
                check_field("status", 8'(rsp.status), 8'(want.status));
                check_field("last", 8'(rsp.last), 8'(want.last));
            end
        end
    end

    // Response side: random stalls, or a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            hold_left = hold_len;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Timeout
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, expected_rsp_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Offer one item, maybe after a gap; entered and left just after a falling edge
    task automatic send_req(req_item_t item);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        advance_timer_table(item);
        req_sent++;
        @(negedge clk);
    endtask

    // Stop sending and wait until every response has come, then let the block settle
    task automatic drain_responses();
        req_valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [31:0] random_period();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return '0;
        else if (roll < 63)
            return $urandom_range(1, 40);
        else if (roll < 90)
            return $urandom_range(41, 1000);
        return $urandom();
    endfunction

    function automatic logic [7:0] random_handler();
        if ($urandom_range(99) < 70)
            return 8'($urandom_range(0, 15));
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly ticks with a moving clock, adds and removes balanced by table fill
    function automatic req_item_t random_req();
        req_item_t it;
        int        roll;
        int        add_share;
        it         = make_req(KIND_TICK, $urandom(), 8'($urandom_range(0, 255)), $urandom());
        roll       = $urandom_range(99);
        add_share  = (tbl_count < 4) ? 40 : (tbl_count >= TBL_DEPTH) ? 8 : 25;
        if (roll < 2)
            it.kind = KIND_UNUSED;
        else if (roll < 50)
        begin
            roll = $urandom_range(99);
            if (roll < 3)
                clock_ms = $urandom();
            else if (roll < 8)
                clock_ms = clock_ms;
            else
                clock_ms = clock_ms + $urandom_range(1, 20);
            it.now_ms = clock_ms;
        end
        else if (roll < 50 + add_share)
        begin
            it.kind      = KIND_ADD;
            it.handler   = random_handler();
            it.period_ms = random_period();
        end
        else
        begin
            it.kind    = KIND_REMOVE;
            it.handler = (tbl_count > 0 && $urandom_range(99) < 75) ?
                         tbl_handler[$urandom_range(0, tbl_count - 1)] : random_handler();
        end
        return it;
    endfunction

    // Empty table, unused kind, zero and maximal intervals, wrap, duplicates
    task automatic test_basic_ops();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_req(make_req(KIND_TICK, 32'h0000_0000, 8'h00, 32'h0000_0000));
        send_req(make_req(KIND_REMOVE, 32'h0000_0000, 8'hFF, 32'h0000_0000));
        send_req(make_req(KIND_UNUSED, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF));
        send_req(make_req(KIND_ADD, 32'h0000_0000, 8'hFF, 32'h0000_0000));
        send_req(make_req(KIND_ADD, 32'h0000_0000, 8'h00, 32'hFFFF_FFFF));
        send_req(make_req(KIND_ADD, 32'h0000_0000, 8'h5A, 32'd10));
        send_req(make_req(KIND_ADD, 32'h0000_0000, 8'h5A, 32'd3));
        send_req(make_req(KIND_TICK, 32'h0000_0000, 8'h00, 32'h0000_0000));
        send_req(make_req(KIND_TICK, 32'd10, 8'h00, 32'h0000_0000));
        send_req(make_req(KIND_TICK, 32'hFFFF_FFFF, 8'h00, 32'h0000_0000));
        send_req(make_req(KIND_TICK, 32'd2, 8'h00, 32'h0000_0000));
        send_req(make_req(KIND_REMOVE, 32'h0000_0000, 8'h5A, 32'h0000_0000));
        send_req(make_req(KIND_REMOVE, 32'h0000_0000, 8'h11, 32'h0000_0000));
        send_req(make_req(KIND_TICK, 32'd5, 8'h00, 32'h0000_0000));
        drain_responses();
    endtask

    // Fill the table, overflow it, fire every slot at once, remove at both ends
    task automatic test_full_table();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (tbl_count < TBL_DEPTH)
            send_req(make_req(KIND_ADD, $urandom(), 8'(8'h80 + tbl_count),
                              32'(tbl_count % 2)));
        send_req(make_req(KIND_ADD, 32'h0000_0000, 8'h77, 32'd1));
        clock_ms = 32'hFFFF_FFFE;
        send_req(make_req(KIND_TICK, clock_ms, 8'h00, 32'h0000_0000));
        send_req(make_req(KIND_TICK, clock_ms, 8'h00, 32'h0000_0000));
        send_req(make_req(KIND_REMOVE, 32'h0000_0000, tbl_handler[0], 32'h0000_0000));
        send_req(make_req(KIND_REMOVE, 32'h0000_0000, tbl_handler[tbl_count - 1],
                          32'h0000_0000));
        drain_responses();
    endtask

    task automatic test_random_traffic(int n_items, int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (n_items)
            send_req(random_req());
        drain_responses();
    endtask

    // Hold the response side off while ticks keep coming, so the block backs up
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (tbl_count < 12)
            send_req(make_req(KIND_ADD, 32'h0000_0000, random_handler(), 32'h0000_0000));
        hold_len = HOLD_OFF_CYCLES;
        hold_seq++;
        repeat (10)
        begin
            clock_ms = clock_ms + 1;
            send_req(make_req(KIND_TICK, clock_ms, 8'h00, 32'h0000_0000));
        end
        drain_responses();
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_basic_ops();
        test_full_table();
        test_random_traffic(95, 38, 61);
        test_backpressure();
        test_random_traffic(95, 61, 38);
        test_random_traffic(70, 0, 0);
        $display("run covered %0d request items and %0d responses in %0d cycles",
                 req_sent, rsp_seen, cycle_count);
        $display("responses: %0d fired slots, %0d full-table adds, %0d missing removes",
                 fired_seen, full_seen, absent_seen);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
